[design/dtc_pkg.sv]
// shared constants and widths for the domino tiling counter
package dtc_pkg;

  localparam int DIM_W     = 4;
  localparam int PROF_W    = 11;
  localparam int ADDR_W    = PROF_W + 1;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int COUNT_W   = 64;
  localparam int TILINGS_W = 63;

  localparam logic [DIM_W-1:0] MAX_ROWS = DIM_W'(11);
  localparam logic [DIM_W-1:0] MAX_COLS = DIM_W'(PROF_W);

endpackage

[design/dtc_in_if.sv]
// query channel: grid height and width
interface dtc_in_if;
  logic                        valid;
  logic                        ready;
  logic [dtc_pkg::DIM_W-1:0]   rows;
  logic [dtc_pkg::DIM_W-1:0]   cols;

  modport source (output valid, output rows, output cols, input ready);
  modport sink   (input valid, input rows, input cols, output ready);
endinterface

[design/dtc_out_if.sv]
// answer channel: tiling count
interface dtc_out_if;
  logic                            valid;
  logic                            ready;
  logic [dtc_pkg::TILINGS_W-1:0]   tilings;

  modport source (output valid, output tilings, input ready);
  modport sink   (input valid, input tilings, output ready);
endinterface

[design/dtc_table.sv]
// ping-pong count memory, one write port and two registered read ports
module dtc_table (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [dtc_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [dtc_pkg::COUNT_W-1:0]  wr_data,
  input  logic [dtc_pkg::ADDR_W-1:0]   rd_addr0,
  input  logic [dtc_pkg::ADDR_W-1:0]   rd_addr1,
  output logic [dtc_pkg::COUNT_W-1:0]  rd_data0,
  output logic [dtc_pkg::COUNT_W-1:0]  rd_data1
);

  logic [dtc_pkg::COUNT_W-1:0] mem [0:dtc_pkg::DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

[design/domino_tiling_counter_top.sv]
// domino tiling counter: broken-profile sweep over a ping-pong count memory
// a grid with even area is swept cell by cell, each cell over all 2^cols profiles
// a zero or out-of-range dimension, or an odd area, skips the sweep and answers zero
// a new query is taken only in idle; a sweep moves one profile per cycle through one 64-bit adder, pausing in drain
// reset: clears the sequencer and output valid, the count memory needs no clearing
module domino_tiling_counter_top (
  input  logic         clk,
  input  logic         rst,
  dtc_in_if.sink       query,
  dtc_out_if.source    answer
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SWEEP   = 6'b000010,
    ST_DRAIN   = 6'b000100,
    ST_FETCH   = 6'b001000,
    ST_COLLECT = 6'b010000,
    ST_FINISH  = 6'b100000
  } state_t;

  state_t state;

  logic [dtc_pkg::DIM_W-1:0]     rows_r;
  logic [dtc_pkg::DIM_W-1:0]     cols_r;
  logic [dtc_pkg::DIM_W-1:0]     row_pos;
  logic [dtc_pkg::DIM_W-1:0]     col_pos;
  logic [dtc_pkg::PROF_W-1:0]    cursor;
  logic                          bank;
  logic                          first;
  logic [dtc_pkg::TILINGS_W-1:0] res_value;

  logic                          s1_valid;
  logic [dtc_pkg::PROF_W-1:0]    s1_q;
  logic                          s1_bank;
  logic                          s1_add;
  logic                          s1_first;
  logic                          s1_zero;

  logic [dtc_pkg::PROF_W-1:0]    here;
  logic [dtc_pkg::PROF_W-1:0]    left;
  logic [dtc_pkg::PROF_W-1:0]    mask;
  logic [dtc_pkg::PROF_W-1:0]    toggled;
  logic                          add_ok;
  logic                          skip;

  logic [dtc_pkg::ADDR_W-1:0]    rd_addr0;
  logic [dtc_pkg::ADDR_W-1:0]    rd_addr1;
  logic [dtc_pkg::COUNT_W-1:0]   rd_data0;
  logic [dtc_pkg::COUNT_W-1:0]   rd_data1;
  logic [dtc_pkg::COUNT_W-1:0]   term0;
  logic [dtc_pkg::COUNT_W-1:0]   term1;
  logic [dtc_pkg::COUNT_W-1:0]   sum;

  assign here    = dtc_pkg::PROF_W'(1) << col_pos;
  assign left    = (col_pos != '0) ? (here >> 1) : '0;
  assign mask    = ~({dtc_pkg::PROF_W{1'b1}} << cols_r);
  assign toggled = cursor ^ here;
  assign add_ok  = (left != '0) && ((cursor & left) == '0) && ((cursor & here) == '0);

  assign skip = (query.rows == '0) || (query.cols == '0) ||
                (query.rows > dtc_pkg::MAX_ROWS) || (query.cols > dtc_pkg::MAX_COLS) ||
                (query.rows[0] && query.cols[0]);

  assign query.ready = (state == ST_IDLE);

  assign rd_addr0 = {bank, (state == ST_SWEEP) ? toggled : {dtc_pkg::PROF_W{1'b0}}};
  assign rd_addr1 = {bank, cursor | left};

  // first pass reads the start table: one at the empty profile
  assign term0 = s1_first ? dtc_pkg::COUNT_W'(s1_zero) : rd_data0;
  assign term1 = (s1_add && !s1_first) ? rd_data1 : '0;
  assign sum   = term0 + term1;

  dtc_table u_table (
    .clk      (clk),
    .wr_en    (s1_valid),
    .wr_addr  ({s1_bank, s1_q}),
    .wr_data  (sum),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  always_ff @(posedge clk) begin
    s1_q     <= cursor;
    s1_bank  <= ~bank;
    s1_add   <= add_ok;
    s1_first <= first;
    s1_zero  <= (toggled == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      s1_valid     <= 1'b0;
      answer.valid <= 1'b0;
      row_pos      <= '0;
      col_pos      <= '0;
      cursor       <= '0;
      bank         <= 1'b0;
      first        <= 1'b0;
    end else begin
      s1_valid <= (state == ST_SWEEP);
      if (answer.valid && answer.ready && (state != ST_FINISH)) begin
        answer.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (query.valid) begin
            rows_r  <= query.rows;
            cols_r  <= query.cols;
            row_pos <= '0;
            col_pos <= '0;
            cursor  <= '0;
            bank    <= 1'b0;
            first   <= 1'b1;
            if (skip) begin
              res_value <= '0;
              state     <= ST_FINISH;
            end else begin
              state <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          if (cursor == mask) begin
            cursor <= '0;
            state  <= ST_DRAIN;
          end else begin
            cursor <= cursor + dtc_pkg::PROF_W'(1);
          end
        end
        ST_DRAIN: begin
          bank  <= ~bank;
          first <= 1'b0;
          if (col_pos == cols_r - dtc_pkg::DIM_W'(1)) begin
            col_pos <= '0;
            if (row_pos == rows_r - dtc_pkg::DIM_W'(1)) begin
              row_pos <= '0;
              state   <= ST_FETCH;
            end else begin
              row_pos <= row_pos + dtc_pkg::DIM_W'(1);
              state   <= ST_SWEEP;
            end
          end else begin
            col_pos <= col_pos + dtc_pkg::DIM_W'(1);
            state   <= ST_SWEEP;
          end
        end
        ST_FETCH: begin
          state <= ST_COLLECT;
        end
        ST_COLLECT: begin
          res_value <= rd_data0[dtc_pkg::TILINGS_W-1:0];
          state     <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!answer.valid || answer.ready) begin
            answer.tilings <= res_value;
            answer.valid   <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // no write may be in flight once a new query can be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !s1_valid)
    else $error("count write pending while idle");

  // writes go only to the bank that is not being read
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_bank != bank))
    else $error("write hits the source bank");

  // the swept cell stays inside the grid
  a_cell_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> ((row_pos < rows_r) && (col_pos < cols_r)))
    else $error("cell position out of grid");

  // the profile cursor stays inside the span of the grid width
  a_cursor_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> ((cursor & ~mask) == '0))
    else $error("profile cursor beyond span");

endmodule
